FILE: rtl/hbp_pkg.sv
`default_nettype none

package hbp_pkg;

  localparam int unsigned SymbolBits = 8;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned LenBits    = 6;
  localparam int unsigned TotalBits  = 40;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned MaxWords   = 4;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]            operation;
    logic [SymbolBits-1:0] symbol;
    logic [WordBits-1:0]   code_word;
    logic [LenBits-1:0]    code_size;
  } in_word_t;

  typedef struct packed {
    logic [ByteBits-1:0]  out_byte;
    logic                 byte_valid;
    logic                 is_final;
    logic [TotalBits-1:0] total_bits;
  } out_word_t;

  typedef struct packed {
    logic [WordBits-1:0] word;
    logic [LenBits-1:0]  len;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/huffman_bit_packer.sv
`default_nettype none

// Variable-length code bit packer.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes three kinds of word:
// load writes one symbol's code word and length into the code table, encode
// appends the symbol's code bits to the stream, flush closes the stream.
// Output channel (out_valid_o / out_ready_i / out_data_o) gives packed bytes,
// earliest bit in the MSB, and on flush one final word with the padded last
// byte (byte_valid low if none) and the saturating total bit count.
// The code table is read at the edge that accepts an item, and the packing
// stage loads the burst buffer from it once that buffer is free. Items that
// emit at most one word pass at one item per cycle while the receiver is
// ready; an encode can emit up to four words, which the byte-wide output port
// drains from the burst buffer before the next item with words can pass.
// Reset clears the stream state (pending bits, bit position, total) and all
// control; the code table is not cleared and must be loaded before use.
// When the receiver stalls, the burst buffer holds its word, the packing stage
// holds its item, and input ready drops once both are occupied.
module huffman_bit_packer
  import hbp_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT  = 256,
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o
);

  localparam int unsigned IdxBits  = $clog2(SYMBOL_COUNT);
  localparam int unsigned LenLimit = (MAX_CODE_BITS < WordBits) ? MAX_CODE_BITS : WordBits;
  localparam int unsigned WinBits  = ByteBits + WordBits;

  // Code table: one write port for load, one registered read port for encode.
  entry_t code_mem_q [SYMBOL_COUNT];
  entry_t rd_entry_q;

  logic in_fire;
  logic sym_in_range;
  logic [IdxBits-1:0] sym_idx;
  logic [LenBits-1:0] len_clamped;

  assign in_fire      = in_valid_i && in_ready_o;
  assign sym_in_range = 32'(in_data_i.symbol) < SYMBOL_COUNT;
  assign sym_idx      = in_data_i.symbol[IdxBits-1:0];
  assign len_clamped  = (in_data_i.code_size > LenBits'(LenLimit)) ?
                        LenBits'(LenLimit) : in_data_i.code_size;

  always_ff @(posedge clk_i) begin
    if (in_fire && sym_in_range && (in_data_i.operation == OP_LOAD)) begin
      code_mem_q[sym_idx] <= '{word: in_data_i.code_word, len: len_clamped};
    end
    if (in_fire && sym_in_range && (in_data_i.operation == OP_ENCODE)) begin
      rd_entry_q <= code_mem_q[sym_idx];
    end
  end

  // Packing stage: item whose table read has completed.
  logic       s1_valid_q;
  logic [1:0] s1_op_q;
  logic       s1_hit_q;

  // Stream state.
  logic [ByteBits-1:0]  pend_q, pend_d;
  logic [2:0]           pos_q, pos_d;
  logic [TotalBits-1:0] total_q, total_d;

  // Burst buffer feeding the output port.
  logic [ByteBits-1:0]  burst_byte_q [MaxWords];
  logic [ByteBits-1:0]  burst_byte_d [MaxWords];
  logic                 burst_busy_q;
  logic [2:0]           burst_cnt_q, burst_cnt_d;
  logic [1:0]           burst_idx_q;
  logic                 burst_final_q, burst_final_d;
  logic                 burst_bvalid_q, burst_bvalid_d;
  logic [TotalBits-1:0] burst_total_q;

  logic burst_last;
  logic burst_free;
  logic s1_advance;

  assign burst_last  = burst_idx_q == 2'(burst_cnt_q - 3'd1);
  assign burst_free  = !burst_busy_q || (out_ready_i && burst_last);

  // Pack the code into a window behind the pending bits.
  logic [LenBits-1:0]  enc_len;
  logic [WordBits-1:0] code_bits;
  logic [LenBits-1:0]  shift_amt;
  logic [WinBits-1:0]  window;
  logic [LenBits-1:0]  fill;
  logic [2:0]          n_bytes;
  logic [TotalBits:0]  total_sum;

  always_comb begin
    enc_len   = (s1_op_q == OP_ENCODE && s1_hit_q) ? rd_entry_q.len : '0;
    code_bits = rd_entry_q.word & ~({WordBits{1'b1}} << enc_len);
    shift_amt = LenBits'(WinBits) - LenBits'(pos_q) - enc_len;
    window    = {pend_q, {WordBits{1'b0}}} | (WinBits'(code_bits) << shift_amt);
    fill      = LenBits'(pos_q) + enc_len;
    n_bytes   = fill[5:3];
    total_sum = {1'b0, total_q} + (TotalBits + 1)'(enc_len);
  end

  always_comb begin
    pend_d         = pend_q;
    pos_d          = pos_q;
    total_d        = total_q;
    burst_cnt_d    = '0;
    burst_final_d  = 1'b0;
    burst_bvalid_d = 1'b1;
    for (int k = 0; k < MaxWords; k++) begin
      burst_byte_d[k] = window[WinBits-1-ByteBits*k -: ByteBits];
    end
    unique case (s1_op_q)
      OP_ENCODE: begin
        burst_cnt_d = n_bytes;
        pos_d       = fill[2:0];
        total_d     = total_sum[TotalBits] ? {TotalBits{1'b1}} : total_sum[TotalBits-1:0];
        unique case (n_bytes)
          3'd0:    pend_d = window[WinBits-1 -: ByteBits];
          3'd1:    pend_d = window[WinBits-1-ByteBits -: ByteBits];
          3'd2:    pend_d = window[WinBits-1-2*ByteBits -: ByteBits];
          3'd3:    pend_d = window[WinBits-1-3*ByteBits -: ByteBits];
          default: pend_d = window[WinBits-1-4*ByteBits -: ByteBits];
        endcase
      end
      OP_FLUSH: begin
        burst_cnt_d     = 3'd1;
        burst_final_d   = 1'b1;
        burst_bvalid_d  = pos_q != 3'd0;
        burst_byte_d[0] = pend_q;
        pend_d          = '0;
        pos_d           = '0;
        total_d         = '0;
      end
      default: begin
      end
    endcase
  end

  // Items with no output word pass without waiting on the burst buffer.
  assign s1_advance = s1_valid_q && ((burst_cnt_d == 3'd0) || burst_free);
  assign in_ready_o = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      pend_q       <= '0;
      pos_q        <= '0;
      total_q      <= '0;
      burst_busy_q <= 1'b0;
      burst_cnt_q  <= '0;
      burst_idx_q  <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_advance) begin
        pend_q  <= pend_d;
        pos_q   <= pos_d;
        total_q <= total_d;
      end
      if (s1_advance && (burst_cnt_d != 3'd0)) begin
        burst_busy_q <= 1'b1;
        burst_cnt_q  <= burst_cnt_d;
        burst_idx_q  <= '0;
      end else if (burst_busy_q && out_ready_i) begin
        if (burst_last) begin
          burst_busy_q <= 1'b0;
        end else begin
          burst_idx_q <= burst_idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q  <= in_data_i.operation;
      s1_hit_q <= sym_in_range;
    end
    if (s1_advance && (burst_cnt_d != 3'd0)) begin
      burst_byte_q   <= burst_byte_d;
      burst_final_q  <= burst_final_d;
      burst_bvalid_q <= burst_bvalid_d;
      burst_total_q  <= total_q;
    end
  end

  assign out_valid_o = burst_busy_q;

  always_comb begin
    out_data_o.out_byte   = burst_byte_q[burst_idx_q];
    out_data_o.byte_valid = burst_bvalid_q;
    out_data_o.is_final   = burst_final_q;
    out_data_o.total_bits = burst_final_q ? burst_total_q : '0;
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import hbp_pkg::*;

  // Operation code that the block leaves unused; it must be dropped silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Code length limit: the smaller of MAX_CODE_BITS and the code word width.
  localparam int unsigned CodeLimit = 32;
  localparam logic [TotalBits-1:0] TotalMax = '1;

  // Tracks the bit stream the packer should build and checks its output words.
  class byte_stream_board;
    logic [WordBits-1:0]  code_words [256];
    logic [LenBits-1:0]   code_lens  [256];
    logic [ByteBits-1:0]  partial_byte;
    int unsigned          fill_count;
    logic [TotalBits-1:0] stream_bits;
    out_word_t            awaited_bytes [$];
    int                   errors;

    function new();
      partial_byte = '0;
      fill_count   = 0;
      stream_bits  = '0;
      errors       = 0;
    endfunction

    function void note_word(in_word_t w);
      logic [WordBits-1:0] code;
      int unsigned         n;
      out_word_t           r;
      case (w.operation)
        OP_LOAD: begin
          code_words[w.symbol] = w.code_word;
          code_lens[w.symbol]  = (w.code_size > CodeLimit) ? LenBits'(CodeLimit)
                                                           : w.code_size;
        end
        OP_ENCODE: begin
          code = code_words[w.symbol];
          n    = code_lens[w.symbol];
          // Shift out the code first bit first, filling each byte from the MSB.
          for (int i = n; i > 0; i--) begin
            if (code[i-1]) partial_byte[7-fill_count] = 1'b1;
            fill_count++;
            if (stream_bits != TotalMax) stream_bits++;
            if (fill_count == 8) begin
              r = '{out_byte: partial_byte, byte_valid: 1'b1, is_final: 1'b0,
                    total_bits: '0};
              awaited_bytes.push_back(r);
              partial_byte = '0;
              fill_count   = 0;
            end
          end
        end
        OP_FLUSH: begin
          r = '{out_byte: (fill_count != 0) ? partial_byte : '0,
                byte_valid: (fill_count != 0), is_final: 1'b1,
                total_bits: stream_bits};
          awaited_bytes.push_back(r);
          partial_byte = '0;
          fill_count   = 0;
          stream_bits  = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_byte(out_word_t r);
      out_word_t e;
      if (awaited_bytes.size() == 0) begin
        $error("output word %h with no word awaited", r);
        errors++;
        return;
      end
      e = awaited_bytes.pop_front();
      if (r.out_byte !== e.out_byte) begin
        $error("out_byte: expected %h, actual %h", e.out_byte, r.out_byte);
        errors++;
      end
      if (r.byte_valid !== e.byte_valid) begin
        $error("byte_valid: expected %b, actual %b", e.byte_valid, r.byte_valid);
        errors++;
      end
      if (r.is_final !== e.is_final) begin
        $error("is_final: expected %b, actual %b", e.is_final, r.is_final);
        errors++;
      end
      if (r.total_bits !== e.total_bits) begin
        $error("total_bits: expected %0d, actual %0d", e.total_bits, r.total_bits);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  byte_stream_board board = new();

  // Sender burst bookkeeping and the set of symbols with a loaded table entry.
  int unsigned  burst_left = 0;
  bit           is_loaded [256];
  logic [7:0]   loaded_syms [$];

  // Receiver stall pattern: a mode held for a stretch of cycles.
  int unsigned  stall_mode  = 0;
  int unsigned  stall_left  = 0;
  int unsigned  stall_phase = 0;

  huffman_bit_packer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

  // Pick a receiver mode per stretch: always ready, coin flip, or ready only
  // when the phase count is a multiple of five, so results back up into the burst buffer.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= (stall_phase % 5 == 0);
    endcase
  end

  // Watch both channels. Check outputs before noting the input of the same
  // edge: no output can stem from a word accepted at that very edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_byte(out_data_o);
      if (in_valid_i && in_ready_o) board.note_word(in_data_i);
    end
  end

  function automatic in_word_t make_word(logic [1:0] op, logic [7:0] sym,
                                         logic [31:0] code, logic [5:0] len);
    in_word_t w;
    w.operation = op;
    w.symbol    = sym;
    w.code_word = code;
    w.code_size = len;
    return w;
  endfunction

  // Drive one word and hold it until accepted. At the start of each burst,
  // drop valid for a random gap (sometimes none) before driving the word.
  task automatic send_word(input in_word_t w);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Load a table entry and remember that the symbol may now be encoded.
  task automatic load_entry(input logic [7:0] sym, input logic [31:0] code,
                            input logic [5:0] len);
    send_word(make_word(OP_LOAD, sym, code, len));
    if (!is_loaded[sym]) begin
      is_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  initial begin
    int unsigned pick;
    logic [5:0]  len;
    logic [7:0]  sym;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, saturated lengths, empty code, empty and
    // partial flushes, a code crossing byte boundaries, unused operation.
    load_entry(8'd0,   32'hFFFF_FFFF, 6'd32);
    load_entry(8'd255, 32'h0000_0000, 6'd63);
    load_entry(8'd1,   32'h0000_0005, 6'd3);
    load_entry(8'd2,   32'hDEAD_BEEF, 6'd0);
    load_entry(8'd3,   32'hAAAA_AAAA, 6'd33);
    load_entry(8'd4,   32'h0000_0001, 6'd1);
    send_word(make_word(OP_FLUSH,  8'd0,   32'h0, 6'd0));
    send_word(make_word(OP_ENCODE, 8'd1,   32'h0, 6'd0));
    send_word(make_word(OP_FLUSH,  8'd0,   32'h0, 6'd0));
    send_word(make_word(OP_ENCODE, 8'd0,   32'h0, 6'd0));
    send_word(make_word(OP_ENCODE, 8'd255, 32'h0, 6'd0));
    send_word(make_word(OP_ENCODE, 8'd2,   32'h0, 6'd0));
    send_word(make_word(OP_ENCODE, 8'd1,   32'h0, 6'd0));
    send_word(make_word(OP_ENCODE, 8'd3,   32'h0, 6'd0));
    send_word(make_word(OP_UNUSED, 8'hFF,  32'hFFFF_FFFF, 6'h3F));
    send_word(make_word(OP_FLUSH,  8'hFF,  32'hFFFF_FFFF, 6'h3F));
    send_word(make_word(OP_ENCODE, 8'd4,   32'h0, 6'd0));
    send_word(make_word(OP_FLUSH,  8'd0,   32'h0, 6'd0));

    // Fill a working code table, then run mostly encodes with the odd
    // reload, flush and unused word mixed in.
    repeat (16) begin
      len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(1, 12));
      load_entry(8'($urandom_range(0, 255)), $urandom, len);
    end
    repeat (85) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(1, 12));
        load_entry(8'($urandom_range(0, 255)), $urandom, len);
      end else if (pick < 84) begin
        // Encode only loaded symbols; carry junk in the unused fields.
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        send_word(make_word(OP_ENCODE, sym, $urandom, 6'($urandom_range(0, 63))));
      end else if (pick < 95) begin
        send_word(make_word(OP_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                            6'($urandom_range(0, 63))));
      end else begin
        send_word(make_word(OP_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                            6'($urandom_range(0, 63))));
      end
    end
    send_word(make_word(OP_FLUSH, 8'd0, 32'h0, 6'd0));
    in_valid_i <= 1'b0;

    // Drain every awaited word, then idle a little longer to catch extras.
    while (board.awaited_bytes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (board.awaited_bytes.size() != 0)
      $error("%0d output words never arrived", board.awaited_bytes.size());
    if (board.errors == 0 && board.awaited_bytes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hbp_pkg.sv
rtl/huffman_bit_packer.sv
test/testbench.sv
